FILE: rtl/mpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared constants and codes of the magnetic presence detector.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int SAMPLE_W  = 16;
  localparam int ELAPSED_W = 32;
  localparam int ALPHA_W   = 16;
  localparam int THR_W     = 17;
  localparam int LEVEL_W   = 2;

  localparam int IN_W  = 80;
  localparam int OUT_W = 24;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;

  localparam logic [CFG_AW-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BALPHA = 3'd1;
  localparam logic [CFG_AW-1:0] REG_OALPHA = 3'd2;
  localparam logic [CFG_AW-1:0] REG_ON     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_OFF    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_STRONG = 3'd5;
  localparam logic [CFG_AW-1:0] REG_ZBLUE  = 3'd6;

  localparam logic [15:0] WINDOW_RST = 16'd1000;
  localparam logic [15:0] BALPHA_RST = 16'd3277;
  localparam logic [15:0] OALPHA_RST = 16'd6554;
  localparam logic [16:0] ON_RST     = 17'd400;
  localparam logic [16:0] OFF_RST    = 17'd300;
  localparam logic [16:0] STRONG_RST = 17'd1100;

  localparam logic [LEVEL_W-1:0] LVL_BUILD  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_ABSENT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_WEAK   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_STRONG = 2'd3;

endpackage

FILE: rtl/magnetic_presence_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetic_presence_detector
// Baseline-subtracted magnitude detector with smoothing and hysteresis.
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   80     sample_x, sample_y, sample_z, elapsed_ms
// m_axis    out  24     running, present, level, team_blue, filtered_magnitude
// cfg       in   3+17   register index, write data
//
// A detection sample is paced by the one-bit-per-cycle square root and the
// shared multiplier used for three squares and four averages.
// The input is ready only while the sequencer is idle.
// A finished result waits in the output register; the next transfer may be
// accepted and worked on meanwhile, and completes once the result is taken.
// Reset is synchronous, restores register defaults and clears the sequencer flags and m_tvalid, not the output fields.
// ----------------------------------------------------------------------------
module magnetic_presence_detector import mpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // sample_x[15:0], sample_y[31:16], sample_z[47:32], elapsed_ms[79:48]
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // running[0], present[1], level[3:2], team_blue[4], filtered_magnitude[21:5]
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int SW   = SAMPLE_W + FRAC_BITS;
  localparam int DW   = SW + 1;
  localparam int MW   = DW + 2;
  localparam int SUMW = 2 * DW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BASE, ST_DEV, ST_SQ, ST_ROOT, ST_FILT, ST_DONE
  } state_t;

  state_t state;
  logic [1:0] idx;

  logic [15:0] window, balpha, oalpha;
  logic [16:0] on_thr, off_thr, strong_thr;
  logic        zblue;

  logic started, finished, filt_started, presence, run_item, win_hit;

  logic signed [SW-1:0] s_q [3];
  logic signed [SW-1:0] base_q [3];
  logic signed [DW-1:0] dev_q [3];
  logic signed [DW-1:0] fdev_q [3];
  logic [DW-1:0]        fmag;
  logic [SUMW-1:0]      acc;

  logic signed [MW-1:0]   ma, mb, v_op, o_op;
  logic signed [2*MW-1:0] prod, prod_sh;
  logic [1:0]             ix;

  logic          sq_start, sq_done;
  logic [DW-1:0] root;

  logic          pres_next, at_strong, zpos;
  logic [DW-1:0] on_sh, off_sh, strong_sh;

  logic             out_running, out_present, out_blue;
  logic [LEVEL_W-1:0] out_level;
  logic [THR_W-1:0] out_fm;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {2'b00, out_fm, out_blue, out_level, out_present, out_running};

  assign ix = (idx == 2'd3) ? 2'd0 : idx;

  always_comb begin
    v_op = (idx == 2'd3) ? MW'({1'b0, root})  : MW'(dev_q[ix]);
    o_op = (idx == 2'd3) ? MW'({1'b0, fmag})  : MW'(fdev_q[ix]);
    ma = '0;
    mb = '0;
    unique case (state)
      ST_BASE: begin
        ma = MW'(s_q[ix]) - MW'(base_q[ix]);
        mb = MW'({1'b0, balpha});
      end
      ST_SQ: begin
        ma = MW'(dev_q[ix]);
        mb = MW'(dev_q[ix]);
      end
      ST_FILT: begin
        ma = v_op - o_op;
        mb = MW'({1'b0, oalpha});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign prod_sh = prod >>> ALPHA_W;

  assign on_sh     = {on_thr, FRAC_BITS'(0)};
  assign off_sh    = {off_thr, FRAC_BITS'(0)};
  assign strong_sh = {strong_thr, FRAC_BITS'(0)};
  assign pres_next = presence ? !(fmag <= off_sh) : (fmag >= on_sh);
  assign at_strong = (fmag >= strong_sh);
  assign zpos      = !fdev_q[2][DW-1];

  mpd_sqrt #(.ROOT_W(DW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (acc),
    .root     (root),
    .done     (sq_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= WINDOW_RST;
      balpha     <= BALPHA_RST;
      oalpha     <= OALPHA_RST;
      on_thr     <= ON_RST;
      off_thr    <= OFF_RST;
      strong_thr <= STRONG_RST;
      zblue      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW: window     <= cfg_data[15:0];
        REG_BALPHA: balpha     <= cfg_data[15:0];
        REG_OALPHA: oalpha     <= cfg_data[15:0];
        REG_ON:     on_thr     <= cfg_data;
        REG_OFF:    off_thr    <= cfg_data;
        REG_STRONG: strong_thr <= cfg_data;
        REG_ZBLUE:  zblue      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      started      <= 1'b0;
      finished     <= 1'b0;
      filt_started <= 1'b0;
      presence     <= 1'b0;
      m_tvalid     <= 1'b0;
      sq_start     <= 1'b0;
      run_item     <= 1'b0;
      win_hit      <= 1'b0;
    end else begin
      sq_start <= (state == ST_SQ) && (idx == 2'd2);
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            s_q[0]   <= SW'({s_tdata[15:0], FRAC_BITS'(0)});
            s_q[1]   <= SW'({s_tdata[31:16], FRAC_BITS'(0)});
            s_q[2]   <= SW'({s_tdata[47:32], FRAC_BITS'(0)});
            win_hit  <= (s_tdata[79:48] >= {16'd0, window});
            run_item <= finished;
            idx      <= '0;
            state    <= finished ? ST_DEV : ST_BASE;
          end
        end
        ST_BASE: begin
          base_q[ix] <= started ? SW'(MW'(base_q[ix]) + prod_sh[MW-1:0]) : s_q[ix];
          if (idx == 2'd2) begin
            started <= 1'b1;
            if (win_hit) begin
              finished <= 1'b1;
            end
            state <= ST_DONE;
          end
          idx <= idx + 1'b1;
        end
        ST_DEV: begin
          for (int i = 0; i < 3; i++) begin
            dev_q[i] <= DW'(s_q[i]) - DW'(base_q[i]);
          end
          acc   <= '0;
          idx   <= '0;
          state <= ST_SQ;
        end
        ST_SQ: begin
          acc <= acc + prod[SUMW-1:0];
          if (idx == 2'd2) begin
            state <= ST_ROOT;
          end
          idx <= idx + 1'b1;
        end
        ST_ROOT: begin
          idx <= '0;
          if (sq_done) begin
            state <= ST_FILT;
          end
        end
        ST_FILT: begin
          if (idx == 2'd3) begin
            fmag <= filt_started ? DW'(o_op + prod_sh[MW-1:0]) : root;
            filt_started <= 1'b1;
            state <= ST_DONE;
          end else begin
            fdev_q[ix] <= filt_started ? DW'(o_op + prod_sh[MW-1:0]) : dev_q[ix];
          end
          idx <= idx + 1'b1;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (run_item) begin
              presence    <= pres_next;
              out_running <= 1'b1;
              out_present <= pres_next;
              out_level   <= pres_next ? (at_strong ? LVL_STRONG : LVL_WEAK) : LVL_ABSENT;
              out_blue    <= pres_next && (zblue ? zpos : !zpos);
              out_fm      <= fmag[DW-1:FRAC_BITS];
            end else begin
              out_running <= 1'b0;
              out_present <= 1'b0;
              out_level   <= LVL_BUILD;
              out_blue    <= 1'b0;
              out_fm      <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_root_in_root_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_ROOT)
    else $error("square root finished outside its wait state");

  a_absent_is_red: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_present |-> !out_blue)
    else $error("team reported while absent");

  a_running_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_running |-> out_level != LVL_BUILD)
    else $error("detection result carries the building level");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transfer accepted while busy");

endmodule

FILE: rtl/mpd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_sqrt
// Iterative integer square root, one root bit per cycle, truncated.
// ----------------------------------------------------------------------------
module mpd_sqrt import mpd_pkg::*; #(
  parameter int ROOT_W = FRAC_BITS_DEF + 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output logic                  done
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("root done without a running iteration");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !start |=> $stable(radicand) || busy || done)
    else $error("root unit left busy without completing");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("root done held longer than one cycle");

endmodule
